### src/npim_pkg.sv
// ----------------------------------------------------------------------------
// npim_pkg
// Shared constants, types, palette table and helpers for the nearest
// palette index match unit.
// ----------------------------------------------------------------------------
package npim_pkg;

    localparam int PIX_W                   = 8;
    localparam int CH_W                    = 6;
    localparam int DIST_W                  = CH_W + 1;
    localparam int ROM_DEPTH               = 256;
    localparam int ROM_IDX_W               = $clog2(ROM_DEPTH);
    localparam int ENTRY_W                 = 3 * CH_W;
    localparam int DEFAULT_PALETTE_ENTRIES = 256;

    localparam logic [DIST_W-1:0]    DIST_INIT         = DIST_W'(1 << CH_W);
    localparam logic [ROM_IDX_W-1:0] WATER_FIRST       = ROM_IDX_W'(208);
    localparam logic [ROM_IDX_W-1:0] WATER_LAST        = ROM_IDX_W'(223);
    localparam logic [ROM_IDX_W-1:0] ORANGE_FIRST      = ROM_IDX_W'(224);
    localparam logic [ROM_IDX_W-1:0] ORANGE_LAST       = ROM_IDX_W'(231);
    localparam logic [PIX_W-1:0]     TRANSPARENT_INDEX = PIX_W'(0);
    localparam logic [PIX_W-1:0]     NEAR_BLACK_INDEX  = PIX_W'(8);

    typedef struct packed {
        logic load;
        logic issue;
        logic result_load;
    } npim_cmd_t;

    typedef struct packed {
        logic in_transparent;
        logic last_addr;
    } npim_sts_t;

    // palette entries as {red, green, blue}
    localparam logic [ENTRY_W-1:0] PALETTE_ROM [ROM_DEPTH] = '{
        {6'd0, 6'd0, 6'd0},    {6'd8, 6'd8, 6'd8},    {6'd16, 6'd16, 6'd16}, {6'd24, 6'd24, 6'd24},
        {6'd32, 6'd32, 6'd32}, {6'd40, 6'd40, 6'd40}, {6'd48, 6'd48, 6'd48}, {6'd56, 6'd56, 6'd56},
        {6'd1, 6'd1, 6'd1},    {6'd9, 6'd9, 6'd9},    {6'd17, 6'd17, 6'd17}, {6'd25, 6'd25, 6'd25},
        {6'd33, 6'd33, 6'd33}, {6'd41, 6'd41, 6'd41}, {6'd49, 6'd49, 6'd49}, {6'd57, 6'd57, 6'd57},
        {6'd0, 6'd0, 6'd0},    {6'd15, 6'd15, 6'd15}, {6'd18, 6'd18, 6'd18}, {6'd21, 6'd21, 6'd21},
        {6'd24, 6'd24, 6'd24}, {6'd27, 6'd27, 6'd27}, {6'd30, 6'd30, 6'd30}, {6'd33, 6'd33, 6'd33},
        {6'd36, 6'd36, 6'd36}, {6'd39, 6'd39, 6'd39}, {6'd42, 6'd42, 6'd42}, {6'd45, 6'd45, 6'd45},
        {6'd48, 6'd48, 6'd48}, {6'd51, 6'd51, 6'd51}, {6'd54, 6'd54, 6'd54}, {6'd57, 6'd57, 6'd57},
        {6'd57, 6'd16, 6'd16}, {6'd54, 6'd18, 6'd18}, {6'd51, 6'd20, 6'd20}, {6'd48, 6'd22, 6'd22},
        {6'd45, 6'd24, 6'd24}, {6'd42, 6'd26, 6'd26}, {6'd39, 6'd28, 6'd28}, {6'd36, 6'd30, 6'd30},
        {6'd57, 6'd0, 6'd0},   {6'd52, 6'd0, 6'd0},   {6'd47, 6'd0, 6'd0},   {6'd42, 6'd0, 6'd0},
        {6'd37, 6'd0, 6'd0},   {6'd32, 6'd0, 6'd0},   {6'd27, 6'd0, 6'd0},   {6'd22, 6'd0, 6'd0},
        {6'd16, 6'd57, 6'd16}, {6'd18, 6'd54, 6'd18}, {6'd20, 6'd51, 6'd20}, {6'd22, 6'd48, 6'd22},
        {6'd24, 6'd45, 6'd24}, {6'd26, 6'd42, 6'd26}, {6'd28, 6'd39, 6'd28}, {6'd30, 6'd36, 6'd30},
        {6'd0, 6'd57, 6'd0},   {6'd0, 6'd52, 6'd0},   {6'd0, 6'd47, 6'd0},   {6'd0, 6'd42, 6'd0},
        {6'd0, 6'd37, 6'd0},   {6'd0, 6'd32, 6'd0},   {6'd0, 6'd27, 6'd0},   {6'd0, 6'd22, 6'd0},
        {6'd16, 6'd16, 6'd57}, {6'd18, 6'd18, 6'd54}, {6'd20, 6'd20, 6'd51}, {6'd22, 6'd22, 6'd48},
        {6'd24, 6'd24, 6'd45}, {6'd26, 6'd26, 6'd42}, {6'd28, 6'd28, 6'd39}, {6'd30, 6'd30, 6'd36},
        {6'd0, 6'd0, 6'd57},   {6'd0, 6'd0, 6'd52},   {6'd0, 6'd0, 6'd47},   {6'd0, 6'd0, 6'd42},
        {6'd0, 6'd0, 6'd37},   {6'd0, 6'd0, 6'd32},   {6'd0, 6'd0, 6'd27},   {6'd0, 6'd0, 6'd22},
        {6'd57, 6'd57, 6'd16}, {6'd54, 6'd54, 6'd18}, {6'd51, 6'd51, 6'd20}, {6'd48, 6'd48, 6'd22},
        {6'd45, 6'd45, 6'd24}, {6'd42, 6'd42, 6'd26}, {6'd39, 6'd39, 6'd28}, {6'd36, 6'd36, 6'd30},
        {6'd57, 6'd57, 6'd0},  {6'd52, 6'd52, 6'd0},  {6'd47, 6'd47, 6'd0},  {6'd42, 6'd42, 6'd0},
        {6'd37, 6'd37, 6'd0},  {6'd32, 6'd32, 6'd0},  {6'd27, 6'd27, 6'd0},  {6'd22, 6'd22, 6'd0},
        {6'd57, 6'd16, 6'd57}, {6'd54, 6'd18, 6'd54}, {6'd51, 6'd20, 6'd51}, {6'd48, 6'd22, 6'd48},
        {6'd45, 6'd24, 6'd45}, {6'd42, 6'd26, 6'd42}, {6'd39, 6'd28, 6'd39}, {6'd36, 6'd30, 6'd36},
        {6'd57, 6'd0, 6'd57},  {6'd52, 6'd0, 6'd52},  {6'd47, 6'd0, 6'd47},  {6'd42, 6'd0, 6'd42},
        {6'd37, 6'd0, 6'd37},  {6'd32, 6'd0, 6'd32},  {6'd27, 6'd0, 6'd27},  {6'd22, 6'd0, 6'd22},
        {6'd16, 6'd57, 6'd57}, {6'd18, 6'd54, 6'd54}, {6'd20, 6'd51, 6'd51}, {6'd22, 6'd48, 6'd48},
        {6'd24, 6'd45, 6'd45}, {6'd26, 6'd42, 6'd42}, {6'd28, 6'd39, 6'd39}, {6'd30, 6'd36, 6'd36},
        {6'd0, 6'd57, 6'd57},  {6'd0, 6'd52, 6'd52},  {6'd0, 6'd47, 6'd47},  {6'd0, 6'd42, 6'd42},
        {6'd0, 6'd37, 6'd37},  {6'd0, 6'd32, 6'd32},  {6'd0, 6'd27, 6'd27},  {6'd0, 6'd22, 6'd22},
        {6'd57, 6'd41, 6'd25}, {6'd52, 6'd36, 6'd20}, {6'd47, 6'd31, 6'd15}, {6'd42, 6'd26, 6'd10},
        {6'd37, 6'd21, 6'd5},  {6'd32, 6'd16, 6'd0},  {6'd27, 6'd11, 6'd0},  {6'd22, 6'd6, 6'd0},
        {6'd50, 6'd40, 6'd30}, {6'd45, 6'd35, 6'd25}, {6'd40, 6'd30, 6'd20}, {6'd35, 6'd25, 6'd15},
        {6'd30, 6'd20, 6'd10}, {6'd25, 6'd15, 6'd5},  {6'd20, 6'd10, 6'd0},  {6'd15, 6'd5, 6'd0},
        {6'd57, 6'd25, 6'd41}, {6'd52, 6'd20, 6'd36}, {6'd47, 6'd15, 6'd31}, {6'd42, 6'd10, 6'd26},
        {6'd37, 6'd5, 6'd21},  {6'd32, 6'd0, 6'd16},  {6'd27, 6'd0, 6'd11},  {6'd22, 6'd0, 6'd6},
        {6'd50, 6'd30, 6'd40}, {6'd45, 6'd25, 6'd35}, {6'd40, 6'd20, 6'd30}, {6'd35, 6'd15, 6'd25},
        {6'd30, 6'd10, 6'd20}, {6'd25, 6'd5, 6'd15},  {6'd20, 6'd0, 6'd10},  {6'd15, 6'd0, 6'd5},
        {6'd0, 6'd18, 6'd6},   {6'd0, 6'd16, 6'd6},   {6'd0, 6'd13, 6'd5},   {6'd0, 6'd11, 6'd5},
        {6'd0, 6'd8, 6'd3},    {6'd0, 6'd6, 6'd2},    {6'd0, 6'd3, 6'd1},    {6'd0, 6'd2, 6'd0},
        {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17},
        {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17},
        {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17},
        {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17},
        {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17},
        {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17}, {6'd17, 6'd17, 6'd17},
        {6'd41, 6'd25, 6'd57}, {6'd36, 6'd20, 6'd52}, {6'd31, 6'd15, 6'd47}, {6'd26, 6'd10, 6'd42},
        {6'd41, 6'd5, 6'd37},  {6'd16, 6'd0, 6'd32},  {6'd11, 6'd0, 6'd27},  {6'd6, 6'd0, 6'd22},
        {6'd40, 6'd30, 6'd50}, {6'd35, 6'd25, 6'd45}, {6'd30, 6'd20, 6'd40}, {6'd25, 6'd15, 6'd35},
        {6'd20, 6'd10, 6'd30}, {6'd15, 6'd5, 6'd25},  {6'd10, 6'd0, 6'd20},  {6'd5, 6'd0, 6'd15},
        {6'd25, 6'd41, 6'd57}, {6'd23, 6'd39, 6'd55}, {6'd21, 6'd37, 6'd53}, {6'd19, 6'd35, 6'd51},
        {6'd17, 6'd33, 6'd49}, {6'd15, 6'd31, 6'd47}, {6'd13, 6'd29, 6'd45}, {6'd11, 6'd27, 6'd43},
        {6'd9, 6'd25, 6'd41},  {6'd7, 6'd23, 6'd39},  {6'd5, 6'd21, 6'd37},  {6'd3, 6'd19, 6'd35},
        {6'd1, 6'd17, 6'd33},  {6'd0, 6'd15, 6'd31},  {6'd0, 6'd13, 6'd29},  {6'd0, 6'd11, 6'd27},
        {6'd57, 6'd15, 6'd0},  {6'd57, 6'd21, 6'd0},  {6'd57, 6'd27, 6'd0},  {6'd57, 6'd33, 6'd0},
        {6'd57, 6'd39, 6'd0},  {6'd57, 6'd45, 6'd0},  {6'd57, 6'd51, 6'd0},  {6'd57, 6'd57, 6'd0},
        {6'd57, 6'd15, 6'd0},  {6'd57, 6'd21, 6'd0},  {6'd57, 6'd27, 6'd0},  {6'd57, 6'd33, 6'd0},
        {6'd57, 6'd39, 6'd0},  {6'd57, 6'd45, 6'd0},  {6'd57, 6'd51, 6'd0},  {6'd57, 6'd57, 6'd0},
        {6'd57, 6'd37, 6'd31}, {6'd51, 6'd33, 6'd27}, {6'd47, 6'd28, 6'd24}, {6'd43, 6'd24, 6'd20},
        {6'd56, 6'd35, 6'd23}, {6'd52, 6'd32, 6'd24}, {6'd48, 6'd30, 6'd22}, {6'd44, 6'd27, 6'd19},
        {6'd28, 6'd18, 6'd18}, {6'd30, 6'd20, 6'd20}, {6'd32, 6'd22, 6'd22}, {6'd34, 6'd24, 6'd24},
        {6'd36, 6'd26, 6'd26}, {6'd38, 6'd28, 6'd28}, {6'd40, 6'd30, 6'd30}, {6'd42, 6'd32, 6'd32}
    };

    function automatic logic entry_excluded(input logic [ROM_IDX_W-1:0] idx,
                                            input logic skip);
        logic in_water;
        logic in_orange;
        in_water  = (idx >= WATER_FIRST) && (idx <= WATER_LAST);
        in_orange = (idx >= ORANGE_FIRST) && (idx <= ORANGE_LAST);
        return skip && (in_water || in_orange);
    endfunction

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [CH_W-1:0] max3(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b,
                                             input logic [CH_W-1:0] c);
        logic [CH_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

### src/nearest_palette_index_match_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_index_match_unit
// Maps an RGBA pixel to the palette index at the smallest Chebyshev distance.
// Steps: accept, a scan that reads one palette entry per cycle, a drain step, then
// the load of the output register (accept goes straight to that load when alpha is
// zero). A new pixel is accepted only when idle, after the last result is loaded;
// the next pixel is taken while a finished result waits in the output register.
// Reset: asynchronous, active low; clears control state and skip_cycling.
// ----------------------------------------------------------------------------
module nearest_palette_index_match_unit #(
    parameter int PALETTE_ENTRIES = npim_pkg::DEFAULT_PALETTE_ENTRIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [npim_pkg::PIX_W-1:0] red,
    input  logic [npim_pkg::PIX_W-1:0] green,
    input  logic [npim_pkg::PIX_W-1:0] blue,
    input  logic [npim_pkg::PIX_W-1:0] alpha,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [npim_pkg::PIX_W-1:0] color_index,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       skip_cycling
);
    import npim_pkg::*;

    npim_cmd_t cmd;
    npim_sts_t sts;

    assign cfg_ready = 1'b1;

    npim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    npim_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_skip    (skip_cycling),
        .cmd         (cmd),
        .sts         (sts),
        .color_index (color_index)
    );

endmodule

### src/npim_datapath.sv
// ----------------------------------------------------------------------------
// npim_datapath
// Pixel registers, palette address counter, registered palette read,
// running best distance and index, and the result register.
// ----------------------------------------------------------------------------
module npim_datapath #(
    parameter int PALETTE_ENTRIES = npim_pkg::DEFAULT_PALETTE_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [npim_pkg::PIX_W-1:0]  red,
    input  logic [npim_pkg::PIX_W-1:0]  green,
    input  logic [npim_pkg::PIX_W-1:0]  blue,
    input  logic [npim_pkg::PIX_W-1:0]  alpha,
    input  logic                        cfg_we,
    input  logic                        cfg_skip,
    input  npim_pkg::npim_cmd_t         cmd,
    output npim_pkg::npim_sts_t         sts,
    output logic [npim_pkg::PIX_W-1:0]  color_index
);
    import npim_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);

    logic [CH_W-1:0]      r_reg;
    logic [CH_W-1:0]      g_reg;
    logic [CH_W-1:0]      b_reg;
    logic                 transparent_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [ENTRY_W-1:0]   ent_reg;
    logic [ROM_IDX_W-1:0] ent_idx_reg;
    logic                 ent_valid_reg;
    logic [DIST_W-1:0]    best_dist_reg;
    logic [ROM_IDX_W-1:0] best_idx_reg;
    logic [PIX_W-1:0]     color_index_reg;
    logic                 skip_cycling_reg;

    logic [ROM_IDX_W-1:0] rom_addr;
    logic [CH_W-1:0]      ent_dist;
    logic                 better;
    logic [CH_W-1:0]      max_ch;
    logic [PIX_W-1:0]     result;

    assign rom_addr = ROM_IDX_W'(addr_reg);

    assign ent_dist = max3(abs_diff(ent_reg[3*CH_W-1:2*CH_W], r_reg),
                           abs_diff(ent_reg[2*CH_W-1:CH_W], g_reg),
                           abs_diff(ent_reg[CH_W-1:0], b_reg));
    assign better = ent_valid_reg && ({1'b0, ent_dist} < best_dist_reg);

    assign max_ch = max3(r_reg, g_reg, b_reg);

    always_comb
    begin
        if (transparent_reg)
            result = TRANSPARENT_INDEX;
        else if ({1'b0, max_ch} <= best_dist_reg)
            result = NEAR_BLACK_INDEX;
        else
            result = PIX_W'(best_idx_reg);
    end

    assign sts.in_transparent = (alpha == '0);
    assign sts.last_addr      = (addr_reg == LAST_ADDR);
    assign color_index        = color_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_cycling_reg <= 1'b0;
            ent_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                skip_cycling_reg <= cfg_skip;
            ent_valid_reg <= cmd.issue && !entry_excluded(rom_addr, skip_cycling_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg           <= red[PIX_W-1:PIX_W-CH_W];
            g_reg           <= green[PIX_W-1:PIX_W-CH_W];
            b_reg           <= blue[PIX_W-1:PIX_W-CH_W];
            transparent_reg <= (alpha == '0);
            addr_reg        <= '0;
            best_dist_reg   <= DIST_INIT;
            best_idx_reg    <= '0;
        end
        else
        begin
            if (cmd.issue)
                addr_reg <= addr_reg + IDX_W'(1);
            if (better)
            begin
                best_dist_reg <= {1'b0, ent_dist};
                best_idx_reg  <= ent_idx_reg;
            end
        end
        ent_reg     <= PALETTE_ROM[rom_addr];
        ent_idx_reg <= rom_addr;
        if (cmd.result_load)
            color_index_reg <= result;
    end

endmodule

### src/npim_ctrl.sv
// ----------------------------------------------------------------------------
// npim_ctrl
// Sequencer for one pixel: accept, palette scan and pipeline drain (both
// skipped when alpha is zero), and hand-off to the output register.
// ----------------------------------------------------------------------------
module npim_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  npim_pkg::npim_sts_t sts,
    output npim_pkg::npim_cmd_t cmd
);
    import npim_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        cmd.load        = 1'b0;
        cmd.issue       = 1'b0;
        cmd.result_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_transparent ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last_addr)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.result_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
